// ----- rtl/tsl_pkg.sv -----
// Shared constants, command and status types for the thread scheduler.
// Used by tsl_ctrl, tsl_dp and the top level; depends on nothing else.
`default_nettype none
package tsl_pkg;

	localparam int MAX_THREADS = 16;
	localparam int NUM_LATCHES = 4;
	localparam int SLOT_W      = $clog2(MAX_THREADS);
	localparam int LINK_W      = SLOT_W + 1;
	localparam int LATCH_W     = (NUM_LATCHES > 1) ? $clog2(NUM_LATCHES) : 1;
	localparam int FILL_W      = SLOT_W + 1;

	localparam logic [LINK_W-1:0] NIL_SLOT = LINK_W'(MAX_THREADS);

	localparam logic [3:0] REQ_CREATE = 4'd0;
	localparam logic [3:0] REQ_YIELD  = 4'd1;
	localparam logic [3:0] REQ_SLEEP  = 4'd2;
	localparam logic [3:0] REQ_EXIT   = 4'd3;
	localparam logic [3:0] REQ_RUN    = 4'd4;
	localparam logic [3:0] REQ_LINIT  = 4'd5;
	localparam logic [3:0] REQ_LAWAIT = 4'd6;
	localparam logic [3:0] REQ_LDOWN  = 4'd7;
	localparam logic [3:0] REQ_TICK   = 4'd8;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_IGNORED = 2'd2;

	localparam int OP_W = 4;
	localparam logic [OP_W-1:0] OP_NONE  = 4'd0;
	localparam logic [OP_W-1:0] OP_LOAD  = 4'd1;
	localparam logic [OP_W-1:0] OP_EXEC  = 4'd2;
	localparam logic [OP_W-1:0] OP_AWAIT = 4'd3;
	localparam logic [OP_W-1:0] OP_REL   = 4'd4;
	localparam logic [OP_W-1:0] OP_INSH  = 4'd5;
	localparam logic [OP_W-1:0] OP_INSW  = 4'd6;
	localparam logic [OP_W-1:0] OP_INSF  = 4'd7;
	localparam logic [OP_W-1:0] OP_WAKE  = 4'd8;
	localparam logic [OP_W-1:0] OP_PICK  = 4'd9;

	localparam logic [2:0] PATH_DONE    = 3'd0;
	localparam logic [2:0] PATH_SCHED   = 3'd1;
	localparam logic [2:0] PATH_INSERT  = 3'd2;
	localparam logic [2:0] PATH_AWAIT   = 3'd3;
	localparam logic [2:0] PATH_RELEASE = 3'd4;

	typedef struct packed {
		logic [OP_W-1:0] op;
	} tsl_cmd_t;

	typedef struct packed {
		logic [2:0] path;
		logic       head_ins;
		logic       walk_more;
		logic       ptr_valid;
		logic       wake_due;
	} tsl_stat_t;

endpackage
`default_nettype wire

// ----- rtl/thread_scheduler_sleep_latch_unit.sv -----
// Top level of the hardware thread scheduler with sleep list and count-down latches.
// Depends on tsl_pkg, tsl_ctrl and tsl_dp.
`default_nettype none
// An event beat is taken at a rising edge where start is high and busy is low; the
// block then works on that one event alone and shows exactly one result beat, marked
// by done for a single cycle, which the receiver must take as it cannot stall. A
// simple event (create, tick, latch init, an await that does not block, a
// count-down that does not release, a run with no live thread, or any ignored
// event) goes from the load step through the execute step to the finish step that
// raises done. Every scheduling decision moves each due sleeper at the list head
// to the ready queue until the head is not due or the list is empty, then picks
// the ready head. A sleep checks the list head and, when it does not go in at the
// head, steps past each entry due no later than it, then finds and links its
// place. An await that blocks joins the latch's wait list before its schedule; a
// count-down that releases readies each waiter. The longest event is a sleep that
// goes to the tail of a full sleep list with every sleeper due, set by the walks
// over the single-ported link store. Busy stays high until the cycle after done.
module thread_scheduler_sleep_latch_unit
	import tsl_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire  [3:0]  req_type,
	input  wire  [7:0]  delay,
	input  wire  [1:0]  latch_index,
	input  wire  [31:0] latch_units,
	output logic        done,
	output logic [3:0]  next_thread,
	output logic        next_is_idle,
	output logic        switched,
	output logic [3:0]  created_slot,
	output logic [1:0]  status,
	output logic [4:0]  live_threads
);

	tsl_cmd_t  cmd;
	tsl_stat_t stat;

	// The sequencer looks at start only while idle, so a beat is accepted when start
	// is high and busy is low.
	tsl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// All scheduler state lives in the datapath; results are held there and are
	// valid in the cycle where done is high.
	tsl_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.req_type     (req_type),
		.delay        (delay),
		.latch_index  (latch_index),
		.latch_units  (latch_units),
		.stat         (stat),
		.next_thread  (next_thread),
		.next_is_idle (next_is_idle),
		.switched     (switched),
		.created_slot (created_slot),
		.status       (status),
		.live_threads (live_threads)
	);

endmodule
`default_nettype wire

// ----- rtl/tsl_ctrl.sv -----
// Sequencer for the scheduler: steps one event through its datapath operations.
// Depends on tsl_pkg; drives tsl_dp through tsl_cmd_t and reads tsl_stat_t.
`default_nettype none
module tsl_ctrl
	import tsl_pkg::*;
(
	input  wire       clk,
	input  wire       arst_n,
	input  wire       start,
	input  tsl_stat_t stat,
	output tsl_cmd_t  cmd,
	output logic      busy,
	output logic      done
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_EXEC  = 4'd1;
	localparam logic [3:0] S_AWAIT = 4'd2;
	localparam logic [3:0] S_REL   = 4'd3;
	localparam logic [3:0] S_INSH  = 4'd4;
	localparam logic [3:0] S_INSW  = 4'd5;
	localparam logic [3:0] S_INSF  = 4'd6;
	localparam logic [3:0] S_WAKE  = 4'd7;
	localparam logic [3:0] S_PICK  = 4'd8;
	localparam logic [3:0] S_FIN   = 4'd9;

	logic [3:0] state_q, state_n;

	always_comb begin
		state_n    = state_q;
		cmd.op     = OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.op  = OP_LOAD;
					state_n = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.op = OP_EXEC;
				case (stat.path)
					PATH_SCHED:   state_n = S_WAKE;
					PATH_INSERT:  state_n = S_INSH;
					PATH_AWAIT:   state_n = S_AWAIT;
					PATH_RELEASE: state_n = S_REL;
					default:      state_n = S_FIN;
				endcase
			end
			S_AWAIT: begin
				cmd.op  = OP_AWAIT;
				state_n = S_WAKE;
			end
			S_REL: begin
				cmd.op = OP_REL;
				if (!stat.ptr_valid) state_n = S_FIN;
			end
			S_INSH: begin
				cmd.op  = OP_INSH;
				state_n = stat.head_ins ? S_WAKE : S_INSW;
			end
			S_INSW: begin
				cmd.op = OP_INSW;
				if (!stat.walk_more) state_n = S_INSF;
			end
			S_INSF: begin
				cmd.op  = OP_INSF;
				state_n = S_WAKE;
			end
			S_WAKE: begin
				cmd.op = OP_WAKE;
				if (!stat.wake_due) state_n = S_PICK;
			end
			S_PICK: begin
				cmd.op  = OP_PICK;
				state_n = S_FIN;
			end
			S_FIN: begin
				state_n    = S_IDLE;
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_n;
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_FIN);

endmodule
`default_nettype wire

// ----- rtl/tsl_dp.sv -----
// Datapath of the scheduler: ready ring, sleep list, latches and thread state.
// Depends on tsl_pkg; sequenced by tsl_ctrl through tsl_cmd_t.
`default_nettype none
module tsl_dp
	import tsl_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  tsl_cmd_t    cmd,
	input  wire  [3:0]  req_type,
	input  wire  [7:0]  delay,
	input  wire  [1:0]  latch_index,
	input  wire  [31:0] latch_units,
	output tsl_stat_t   stat,
	output logic [3:0]  next_thread,
	output logic        next_is_idle,
	output logic        switched,
	output logic [3:0]  created_slot,
	output logic [1:0]  status,
	output logic [4:0]  live_threads
);

	// Captured event.
	logic [3:0]  req_q;
	logic [7:0]  delay_q;
	logic [1:0]  li_q;
	logic [31:0] units_q;

	// Stores without a reset value.
	logic [SLOT_W-1:0] ring_q [MAX_THREADS];
	logic [31:0]       wake_q [MAX_THREADS];
	logic [LINK_W-1:0] link_q [MAX_THREADS];

	// Control state.
	logic [SLOT_W-1:0] rhead_q, n_rhead;
	logic [FILL_W-1:0] rfill_q, n_rfill;
	logic [LINK_W-1:0] shead_q, n_shead;
	logic [31:0]       lcount_q [NUM_LATCHES];
	logic [31:0]       n_lcount [NUM_LATCHES];
	logic [LINK_W-1:0] lhead_q [NUM_LATCHES];
	logic [LINK_W-1:0] n_lhead [NUM_LATCHES];
	logic [LINK_W-1:0] ltail_q [NUM_LATCHES];
	logic [LINK_W-1:0] n_ltail [NUM_LATCHES];
	logic [SLOT_W-1:0] cur_q, n_cur;
	logic              idle_q, n_idle;
	logic [FILL_W-1:0] total_q, n_total;
	logic [31:0]       now_q, n_now;
	logic [MAX_THREADS-1:0] used_q, n_used;
	logic [SLOT_W-1:0] created_q, n_created;
	logic [1:0]        status_q, n_status;
	logic              switched_q, n_switched;
	logic [31:0]       wt_q, n_wt;
	logic [LINK_W-1:0] ptr_q, n_ptr;

	// Write ports and read ports of the stores.
	logic              push_en;
	logic [SLOT_W-1:0] push_slot, push_pos;
	logic              link_we, wake_we;
	logic [SLOT_W-1:0] link_wa, link_ra, wake_ra;
	logic [LINK_W-1:0] link_wd, link_rd;
	logic [31:0]       wake_wd, wake_rd;

	logic [LATCH_W-1:0] li;
	logic               latch_ok, on_thread, free_found;
	logic [SLOT_W-1:0]  free_slot;
	logic [2:0]         path;

	assign li        = LATCH_W'(li_q);
	assign latch_ok  = (32'(li_q) < NUM_LATCHES);
	assign on_thread = !idle_q;
	assign push_pos  = rhead_q + rfill_q[SLOT_W-1:0];
	assign link_rd   = link_q[link_ra];
	assign wake_rd   = wake_q[wake_ra];

	always_comb begin
		free_found = 1'b0;
		free_slot  = '0;
		for (int i = MAX_THREADS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_found = 1'b1;
				free_slot  = SLOT_W'(i);
			end
		end
	end

	always_comb begin
		link_ra = '0;
		wake_ra = '0;
		case (cmd.op)
			OP_INSH: wake_ra = shead_q[SLOT_W-1:0];
			OP_INSW: begin
				link_ra = ptr_q[SLOT_W-1:0];
				wake_ra = link_rd[SLOT_W-1:0];
			end
			OP_WAKE: begin
				link_ra = shead_q[SLOT_W-1:0];
				wake_ra = shead_q[SLOT_W-1:0];
			end
			OP_REL:  link_ra = ptr_q[SLOT_W-1:0];
			default: ;
		endcase
	end

	always_comb begin
		stat.path      = path;
		stat.head_ins  = (shead_q == NIL_SLOT) || (wake_rd > wt_q);
		stat.walk_more = (link_rd != NIL_SLOT) && (wake_rd <= wt_q);
		stat.ptr_valid = (ptr_q != NIL_SLOT);
		stat.wake_due  = (shead_q != NIL_SLOT) && (now_q >= wake_rd);
	end

	always_comb begin
		n_rhead    = rhead_q;
		n_rfill    = rfill_q;
		n_shead    = shead_q;
		n_lcount   = lcount_q;
		n_lhead    = lhead_q;
		n_ltail    = ltail_q;
		n_cur      = cur_q;
		n_idle     = idle_q;
		n_total    = total_q;
		n_now      = now_q;
		n_used     = used_q;
		n_created  = created_q;
		n_status   = status_q;
		n_switched = switched_q;
		n_wt       = wt_q;
		n_ptr      = ptr_q;
		push_en    = 1'b0;
		push_slot  = '0;
		link_we    = 1'b0;
		link_wa    = '0;
		link_wd    = '0;
		wake_we    = 1'b0;
		wake_wd    = '0;
		path       = PATH_DONE;

		case (cmd.op)
			OP_LOAD: begin
				n_status   = ST_OK;
				n_switched = 1'b0;
				n_created  = '0;
			end
			OP_EXEC: begin
				case (req_q)
					REQ_CREATE: begin
						if (!free_found) begin
							n_status = ST_FULL;
						end else begin
							n_used[free_slot] = 1'b1;
							n_total   = total_q + FILL_W'(1);
							push_en   = 1'b1;
							push_slot = free_slot;
							n_created = free_slot;
						end
					end
					REQ_YIELD: begin
						if (!on_thread) begin
							n_status = ST_IGNORED;
						end else begin
							push_en    = 1'b1;
							push_slot  = cur_q;
							n_switched = 1'b1;
							path       = PATH_SCHED;
						end
					end
					REQ_SLEEP: begin
						if (!on_thread) begin
							n_status = ST_IGNORED;
						end else begin
							n_wt       = now_q + 32'(delay_q);
							wake_we    = 1'b1;
							wake_wd    = now_q + 32'(delay_q);
							n_switched = 1'b1;
							path       = PATH_INSERT;
						end
					end
					REQ_EXIT: begin
						if (!on_thread) begin
							n_status = ST_IGNORED;
						end else begin
							n_used[cur_q] = 1'b0;
							if (total_q != '0) n_total = total_q - FILL_W'(1);
							n_switched = 1'b1;
							path       = PATH_SCHED;
						end
					end
					REQ_RUN: begin
						if (!idle_q) begin
							n_status = ST_IGNORED;
						end else if (total_q != '0) begin
							n_switched = 1'b1;
							path       = PATH_SCHED;
						end
					end
					REQ_LINIT: begin
						if (!latch_ok) begin
							n_status = ST_IGNORED;
						end else begin
							n_lcount[li] = units_q;
							n_lhead[li]  = NIL_SLOT;
							n_ltail[li]  = NIL_SLOT;
						end
					end
					REQ_LAWAIT: begin
						if (!latch_ok || !on_thread) begin
							n_status = ST_IGNORED;
						end else if (lcount_q[li] != '0) begin
							link_we    = 1'b1;
							link_wa    = cur_q;
							link_wd    = NIL_SLOT;
							n_switched = 1'b1;
							path       = PATH_AWAIT;
						end
					end
					REQ_LDOWN: begin
						if (!latch_ok) begin
							n_status = ST_IGNORED;
						end else if (lcount_q[li] != '0) begin
							n_lcount[li] = lcount_q[li] - 32'd1;
							if (lcount_q[li] == 32'd1) begin
								n_ptr       = lhead_q[li];
								n_lhead[li] = NIL_SLOT;
								n_ltail[li] = NIL_SLOT;
								path        = PATH_RELEASE;
							end
						end
					end
					REQ_TICK: n_now = now_q + 32'd1;
					default:  n_status = ST_IGNORED;
				endcase
			end
			OP_AWAIT: begin
				if (ltail_q[li] != NIL_SLOT) begin
					link_we = 1'b1;
					link_wa = ltail_q[li][SLOT_W-1:0];
					link_wd = LINK_W'(cur_q);
				end else begin
					n_lhead[li] = LINK_W'(cur_q);
				end
				n_ltail[li] = LINK_W'(cur_q);
			end
			OP_REL: begin
				if (ptr_q != NIL_SLOT) begin
					push_en   = 1'b1;
					push_slot = ptr_q[SLOT_W-1:0];
					n_ptr     = link_rd;
				end
			end
			OP_INSH: begin
				if (stat.head_ins) begin
					link_we = 1'b1;
					link_wa = cur_q;
					link_wd = shead_q;
					n_shead = LINK_W'(cur_q);
				end else begin
					n_ptr = shead_q;
				end
			end
			OP_INSW: begin
				if (stat.walk_more) begin
					n_ptr = link_rd;
				end else begin
					link_we = 1'b1;
					link_wa = cur_q;
					link_wd = link_rd;
				end
			end
			OP_INSF: begin
				link_we = 1'b1;
				link_wa = ptr_q[SLOT_W-1:0];
				link_wd = LINK_W'(cur_q);
			end
			OP_WAKE: begin
				if (stat.wake_due) begin
					push_en   = 1'b1;
					push_slot = shead_q[SLOT_W-1:0];
					n_shead   = link_rd;
				end
			end
			OP_PICK: begin
				if (rfill_q != '0) begin
					n_cur   = ring_q[rhead_q];
					n_rhead = rhead_q + SLOT_W'(1);
					n_rfill = rfill_q - FILL_W'(1);
					n_idle  = 1'b0;
				end else begin
					n_idle = 1'b1;
				end
			end
			default: ;
		endcase

		if (push_en && (rfill_q < FILL_W'(MAX_THREADS))) n_rfill = n_rfill + FILL_W'(1);
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD) begin
			req_q   <= req_type;
			delay_q <= delay;
			li_q    <= latch_index;
			units_q <= latch_units;
		end
		if (push_en && (rfill_q < FILL_W'(MAX_THREADS))) ring_q[push_pos] <= push_slot;
		if (link_we) link_q[link_wa] <= link_wd;
		if (wake_we) wake_q[cur_q] <= wake_wd;
		wt_q <= n_wt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rhead_q    <= '0;
			rfill_q    <= '0;
			shead_q    <= NIL_SLOT;
			for (int i = 0; i < NUM_LATCHES; i++) begin
				lcount_q[i] <= '0;
				lhead_q[i]  <= NIL_SLOT;
				ltail_q[i]  <= NIL_SLOT;
			end
			cur_q      <= '0;
			idle_q     <= 1'b1;
			total_q    <= '0;
			now_q      <= '0;
			used_q     <= '0;
			created_q  <= '0;
			status_q   <= ST_OK;
			switched_q <= 1'b0;
			ptr_q      <= NIL_SLOT;
		end else begin
			rhead_q    <= n_rhead;
			rfill_q    <= n_rfill;
			shead_q    <= n_shead;
			lcount_q   <= n_lcount;
			lhead_q    <= n_lhead;
			ltail_q    <= n_ltail;
			cur_q      <= n_cur;
			idle_q     <= n_idle;
			total_q    <= n_total;
			now_q      <= n_now;
			used_q     <= n_used;
			created_q  <= n_created;
			status_q   <= n_status;
			switched_q <= n_switched;
			ptr_q      <= n_ptr;
		end
	end

	assign next_thread  = idle_q ? 4'd0 : 4'(cur_q);
	assign next_is_idle = idle_q;
	assign switched     = switched_q;
	assign created_slot = 4'(created_q);
	assign status       = status_q;
	assign live_threads = 5'(total_q);

endmodule
`default_nettype wire
